// ----- hdl/char_lcd_nibble_write_sequencer_top_defines.svh -----
// ----------------------------------------------------------------------------
// LCD write sequencer assertion macros
// Concurrent assertion wrappers; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define LCDS_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LCDS_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LCDS_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define LCDS_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg)
`endif

`endif

// ----- hdl/lcdseq_pkg.sv -----
// ----------------------------------------------------------------------------
// LCD write sequencer package
// Transfer types, request codes and the microcode ROM of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] byte_value;
	} lcds_in_t;

	typedef struct packed {
		logic       reg_select;
		logic       enable_pin;
		logic [3:0] data_nibble;
		logic [4:0] hold_ms;
		logic       last_phase;
	} lcds_out_t;

	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_CMD  = 2'd1;
	localparam logic [1:0] OP_DATA = 2'd2;

	typedef enum logic [1:0] {
		NIB_CONST,
		NIB_HI,
		NIB_LO
	} nib_sel_t;

	typedef struct packed {
		logic       enable;
		nib_sel_t   nib_sel;
		logic [3:0] nib;
		logic [4:0] hold;
		logic       last;
	} ucw_t;

	localparam int UC_DEPTH = 37;
	localparam int PC_W     = $clog2(UC_DEPTH);

	localparam logic [PC_W-1:0] UC_INIT = PC_W'(0);
	localparam logic [PC_W-1:0] UC_BYTE = PC_W'(33);
	localparam logic [PC_W-1:0] UC_LAST = PC_W'(UC_DEPTH - 1);

	localparam logic [4:0] STROBE_MS  = 5'd2;
	localparam logic [4:0] POWERUP_MS = 5'd20;

	function automatic ucw_t cw(input logic e, input nib_sel_t sel, input logic [3:0] nib,
			input logic [4:0] hold, input logic last);
		ucw_t w;
		w.enable  = e;
		w.nib_sel = sel;
		w.nib     = nib;
		w.hold    = hold;
		w.last    = last;
		return w;
	endfunction

	// Init: power-up idle, then 03,03,03,02,28,0C,06,01 as full bytes.
	// Byte routine: nibbles taken from the latched byte.
	function automatic ucw_t uc_rom(input logic [PC_W-1:0] pc);
		ucw_t w;
		case (pc)
			6'd0:  w = cw(1'b0, NIB_CONST, 4'h0, POWERUP_MS, 1'b0);
			// 0x03, 5 ms
			6'd1:  w = cw(1'b1, NIB_CONST, 4'h0, STROBE_MS, 1'b0);
			6'd2:  w = cw(1'b0, NIB_CONST, 4'h0, 5'd0, 1'b0);
			6'd3:  w = cw(1'b1, NIB_CONST, 4'h3, STROBE_MS, 1'b0);
			6'd4:  w = cw(1'b0, NIB_CONST, 4'h3, 5'd5, 1'b0);
			// 0x03, 5 ms
			6'd5:  w = cw(1'b1, NIB_CONST, 4'h0, STROBE_MS, 1'b0);
			6'd6:  w = cw(1'b0, NIB_CONST, 4'h0, 5'd0, 1'b0);
			6'd7:  w = cw(1'b1, NIB_CONST, 4'h3, STROBE_MS, 1'b0);
			6'd8:  w = cw(1'b0, NIB_CONST, 4'h3, 5'd5, 1'b0);
			// 0x03, 1 ms
			6'd9:  w = cw(1'b1, NIB_CONST, 4'h0, STROBE_MS, 1'b0);
			6'd10: w = cw(1'b0, NIB_CONST, 4'h0, 5'd0, 1'b0);
			6'd11: w = cw(1'b1, NIB_CONST, 4'h3, STROBE_MS, 1'b0);
			6'd12: w = cw(1'b0, NIB_CONST, 4'h3, 5'd1, 1'b0);
			// 0x02, 1 ms
			6'd13: w = cw(1'b1, NIB_CONST, 4'h0, STROBE_MS, 1'b0);
			6'd14: w = cw(1'b0, NIB_CONST, 4'h0, 5'd0, 1'b0);
			6'd15: w = cw(1'b1, NIB_CONST, 4'h2, STROBE_MS, 1'b0);
			6'd16: w = cw(1'b0, NIB_CONST, 4'h2, 5'd1, 1'b0);
			// 0x28, 1 ms
			6'd17: w = cw(1'b1, NIB_CONST, 4'h2, STROBE_MS, 1'b0);
			6'd18: w = cw(1'b0, NIB_CONST, 4'h2, 5'd0, 1'b0);
			6'd19: w = cw(1'b1, NIB_CONST, 4'h8, STROBE_MS, 1'b0);
			6'd20: w = cw(1'b0, NIB_CONST, 4'h8, 5'd1, 1'b0);
			// 0x0C, 1 ms
			6'd21: w = cw(1'b1, NIB_CONST, 4'h0, STROBE_MS, 1'b0);
			6'd22: w = cw(1'b0, NIB_CONST, 4'h0, 5'd0, 1'b0);
			6'd23: w = cw(1'b1, NIB_CONST, 4'hC, STROBE_MS, 1'b0);
			6'd24: w = cw(1'b0, NIB_CONST, 4'hC, 5'd1, 1'b0);
			// 0x06, 1 ms
			6'd25: w = cw(1'b1, NIB_CONST, 4'h0, STROBE_MS, 1'b0);
			6'd26: w = cw(1'b0, NIB_CONST, 4'h0, 5'd0, 1'b0);
			6'd27: w = cw(1'b1, NIB_CONST, 4'h6, STROBE_MS, 1'b0);
			6'd28: w = cw(1'b0, NIB_CONST, 4'h6, 5'd1, 1'b0);
			// 0x01, 2 ms
			6'd29: w = cw(1'b1, NIB_CONST, 4'h0, STROBE_MS, 1'b0);
			6'd30: w = cw(1'b0, NIB_CONST, 4'h0, 5'd0, 1'b0);
			6'd31: w = cw(1'b1, NIB_CONST, 4'h1, STROBE_MS, 1'b0);
			6'd32: w = cw(1'b0, NIB_CONST, 4'h1, 5'd2, 1'b1);
			// byte routine
			6'd33: w = cw(1'b1, NIB_HI, 4'h0, STROBE_MS, 1'b0);
			6'd34: w = cw(1'b0, NIB_HI, 4'h0, 5'd0, 1'b0);
			6'd35: w = cw(1'b1, NIB_LO, 4'h0, STROBE_MS, 1'b0);
			6'd36: w = cw(1'b0, NIB_LO, 4'h0, 5'd0, 1'b1);
			default: w = cw(1'b0, NIB_CONST, 4'h0, 5'd0, 1'b1);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/char_lcd_nibble_write_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// Character LCD 4-bit write sequencer
// Turns init, command and data requests into timed RS/E/D7..D4 phases.
// ----------------------------------------------------------------------------
// One request is taken when the sequencer is free; it then gives one phase per
// clock while the output side does not stall, from a 37-word microcode ROM,
// stepped by a program counter, into an output register. An init request gives
// 33 phases (20 ms idle, then eight command bytes), a command or data request
// gives 4; the sequencer goes free once the word flagged last is stepped out,
// and no new request is taken before then. A request with op 3 is taken and
// dropped. The phase hold times are reported in hold_ms for the pin driver
// to time out; this block does not wait them.
`default_nettype none
`include "char_lcd_nibble_write_sequencer_top_defines.svh"

module char_lcd_nibble_write_sequencer_top
	import lcdseq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire lcds_in_t  in_item,
	output      logic      out_valid,
	input  wire logic      out_ready,
	output      lcds_out_t out_item
);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            rs_q;
	logic [7:0]      byte_q;
	logic            out_valid_q;
	lcds_out_t       out_q;

	ucw_t       ucw;
	logic [3:0] nib;
	logic       advance;
	logic       in_xfer;

	assign in_ready  = !busy_q;
	assign in_xfer   = in_valid && in_ready;
	assign advance   = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		ucw = uc_rom(pc_q);
		case (ucw.nib_sel)
			NIB_CONST: nib = ucw.nib;
			NIB_HI:    nib = byte_q[7:4];
			NIB_LO:    nib = byte_q[3:0];
			default:   nib = ucw.nib;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= UC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (advance) begin
				out_valid_q <= 1'b1;
				pc_q        <= pc_q + PC_W'(1);
				if (ucw.last)
					busy_q <= 1'b0;
			end
			if (in_xfer) begin
				case (in_item.op)
					OP_INIT: begin
						pc_q   <= UC_INIT;
						busy_q <= 1'b1;
					end
					OP_CMD, OP_DATA: begin
						pc_q   <= UC_BYTE;
						busy_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rs_q   <= (in_item.op == OP_DATA);
			byte_q <= in_item.byte_value;
		end
		if (advance) begin
			out_q.reg_select  <= rs_q && (pc_q >= UC_BYTE);
			out_q.enable_pin  <= ucw.enable;
			out_q.data_nibble <= nib;
			out_q.hold_ms     <= ucw.hold;
			out_q.last_phase  <= ucw.last;
		end
	end

	`LCDS_ASSERT(a_pc_in_range, clk, arst_n, !busy_q || (pc_q <= UC_LAST),
		"program counter past end of microcode")
	`LCDS_ASSERT_NEXT(a_stall_holds_pc, clk, arst_n,
		busy_q && out_valid_q && !out_ready, $stable(pc_q),
		"sequencer stepped while output stalled")
	`LCDS_ASSERT_NEXT(a_byte_entry, clk, arst_n,
		in_xfer && (in_item.op == OP_CMD || in_item.op == OP_DATA),
		busy_q && (pc_q == UC_BYTE), "byte request did not enter byte routine")
	`LCDS_ASSERT_NEXT(a_init_entry, clk, arst_n, in_xfer && (in_item.op == OP_INIT),
		busy_q && (pc_q == UC_INIT), "init request did not enter init routine")

endmodule

`default_nettype wire

// ----- tb/char_lcd_nibble_write_sequencer_top_tb.sv -----
// ----------------------------------------------------------------------------
// Character LCD 4-bit write sequencer testbench
// Sends init, command, data and undefined requests over the request channel.
// Every phase that comes back is checked field by field against a local
// model of the pin sequence, or against typed nibbles for some directed rows.
// Both channels idle at random, except in the last random round.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_sequencer_top_tb;
	import lcdseq_pkg::*;

	localparam logic [1:0] OP_UNDEF = 2'd3;
	localparam int RANDOM_PER_PHASE = 50;
	localparam int STALL_LIMIT      = 2000;
	localparam int DRAIN_CYCLES     = 50;

	// init command bytes and their trailing delays, first command in the top slot
	localparam logic [63:0] INIT_CMDS  = 64'h03_03_03_02_28_0C_06_01;
	localparam logic [39:0] INIT_TAILS = {5'd5, 5'd5, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd2};

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_TYPED_BYTE,
		CHK_DROPPED
	} chk_t;

	typedef struct packed {
		chk_t       chk;
		logic [1:0] op;
		logic [7:0] byte_value;
		logic       rs;
		logic [3:0] hi;
		logic [3:0] lo;
	} req_row_t;

	localparam int N_DIRECTED = 16;

	req_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{CHK_TYPED_BYTE, OP_DATA,  8'h00, 1'b1, 4'h0, 4'h0},
		'{CHK_TYPED_BYTE, OP_DATA,  8'hFF, 1'b1, 4'hF, 4'hF},
		'{CHK_TYPED_BYTE, OP_CMD,   8'h00, 1'b0, 4'h0, 4'h0},
		'{CHK_TYPED_BYTE, OP_CMD,   8'hFF, 1'b0, 4'hF, 4'hF},
		'{CHK_MODEL,      OP_INIT,  8'h00, 1'b0, 4'h0, 4'h0},
		'{CHK_DROPPED,    OP_UNDEF, 8'hFF, 1'b0, 4'h0, 4'h0},
		'{CHK_MODEL,      OP_INIT,  8'hFF, 1'b0, 4'h0, 4'h0},
		'{CHK_MODEL,      OP_INIT,  8'h5A, 1'b0, 4'h0, 4'h0},
		'{CHK_MODEL,      OP_CMD,   8'hA5, 1'b0, 4'h0, 4'h0},
		'{CHK_MODEL,      OP_DATA,  8'h5A, 1'b0, 4'h0, 4'h0},
		'{CHK_DROPPED,    OP_UNDEF, 8'h00, 1'b0, 4'h0, 4'h0},
		'{CHK_MODEL,      OP_DATA,  8'h41, 1'b0, 4'h0, 4'h0},
		'{CHK_MODEL,      OP_CMD,   8'h01, 1'b0, 4'h0, 4'h0},
		'{CHK_MODEL,      OP_CMD,   8'h80, 1'b0, 4'h0, 4'h0},
		'{CHK_MODEL,      OP_DATA,  8'h3C, 1'b0, 4'h0, 4'h0},
		'{CHK_MODEL,      OP_CMD,   8'hC3, 1'b0, 4'h0, 4'h0}
	};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	lcds_in_t  in_item;
	logic      out_valid;
	logic      out_ready = 1'b0;
	lcds_out_t out_item;

	lcds_out_t pending_phases [$];
	int        mismatch_count = 0;
	int        stall_cycles   = 0;
	int        send_idle_pct  = 35;
	int        recv_stall_pct = 73;

	char_lcd_nibble_write_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
		mismatch_count++;
	endtask

	function automatic void queue_byte_phases(input logic rs, input logic [7:0] b,
			input logic [4:0] tail_ms, input logic last);
		pending_phases.push_back(lcds_out_t'{rs, 1'b1, b[7:4], STROBE_MS, 1'b0});
		pending_phases.push_back(lcds_out_t'{rs, 1'b0, b[7:4], 5'd0, 1'b0});
		pending_phases.push_back(lcds_out_t'{rs, 1'b1, b[3:0], STROBE_MS, 1'b0});
		pending_phases.push_back(lcds_out_t'{rs, 1'b0, b[3:0], tail_ms, last});
	endfunction

	// pin phases caused by one request; undefined ops give none
	function automatic void queue_lcd_phases(input lcds_in_t req);
		case (req.op)
			OP_INIT: begin
				pending_phases.push_back(lcds_out_t'{1'b0, 1'b0, 4'h0, POWERUP_MS, 1'b0});
				for (int i = 0; i < 8; i++)
					queue_byte_phases(1'b0, INIT_CMDS[63-8*i -: 8], INIT_TAILS[39-5*i -: 5],
						i == 7);
			end
			OP_CMD:  queue_byte_phases(1'b0, req.byte_value, 5'd0, 1'b1);
			OP_DATA: queue_byte_phases(1'b1, req.byte_value, 5'd0, 1'b1);
			default: ;
		endcase
	endfunction

	// called just after a falling edge; returns just after the falling edge that follows acceptance
	task automatic send_request(input req_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_item  = '{row.op, row.byte_value};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		case (row.chk)
			CHK_TYPED_BYTE: begin
				pending_phases.push_back(lcds_out_t'{row.rs, 1'b1, row.hi, 5'd2, 1'b0});
				pending_phases.push_back(lcds_out_t'{row.rs, 1'b0, row.hi, 5'd0, 1'b0});
				pending_phases.push_back(lcds_out_t'{row.rs, 1'b1, row.lo, 5'd2, 1'b0});
				pending_phases.push_back(lcds_out_t'{row.rs, 1'b0, row.lo, 5'd0, 1'b1});
			end
			CHK_DROPPED: ;
			default: queue_lcd_phases(in_item);
		endcase
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : phase_check
		lcds_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_phases.size() == 0) begin
				report_mismatch("phase with nothing pending", 0, out_item);
			end else begin
				want = pending_phases.pop_front();
				if (out_item.reg_select !== want.reg_select)
					report_mismatch("reg_select", want.reg_select, out_item.reg_select);
				if (out_item.enable_pin !== want.enable_pin)
					report_mismatch("enable_pin", want.enable_pin, out_item.enable_pin);
				if (out_item.data_nibble !== want.data_nibble)
					report_mismatch("data_nibble", want.data_nibble, out_item.data_nibble);
				if (out_item.hold_ms !== want.hold_ms)
					report_mismatch("hold_ms", want.hold_ms, out_item.hold_ms);
				if (out_item.last_phase !== want.last_phase)
					report_mismatch("last_phase", want.last_phase, out_item.last_phase);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("char_lcd_nibble_write_sequencer_top test failed");
				$finish;
			end
		end
	end

	initial begin
		int       counted;
		int       pick;
		req_row_t row;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_request(directed_rows[i]);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct  = (phase == 0) ? 35 : (phase == 1) ? 73 : 0;
			recv_stall_pct = (phase == 0) ? 73 : (phase == 1) ? 35 : 0;
			counted = 0;
			while (counted < RANDOM_PER_PHASE) begin
				pick           = $urandom_range(99);
				row            = '0;
				row.chk        = CHK_MODEL;
				row.byte_value = 8'($urandom_range(255));
				if (pick < 10)
					row.op = OP_INIT;
				else if (pick < 50)
					row.op = OP_CMD;
				else if (pick < 90)
					row.op = OP_DATA;
				else
					row.op = OP_UNDEF;
				send_request(row);
				// dropped requests do not count towards the total
				if (row.op != OP_UNDEF)
					counted++;
			end
		end
		in_valid = 1'b0;

		while (pending_phases.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("char_lcd_nibble_write_sequencer_top test passed");
		else
			$display("char_lcd_nibble_write_sequencer_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
